// ===== rtl/core/fkvc_pkg.sv =====
// Package for the FIFO-replacement key/value cache core.
// Field widths, operation codes, controller states and command struct.
// No dependencies.
package fkvc_pkg;

  localparam int unsigned KEY_W        = 32;
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned OP_W         = 2;
  localparam int unsigned CAPACITY_DEF = 8;

  // input tdata: item_key [31:0], item_value [63:32]
  localparam int unsigned IN_DATA_W  = 64;
  // output tdata: read_value [31:0]
  localparam int unsigned OUT_DATA_W = 32;

  // operation codes carried on s_axis_tuser; code 3 changes no entry and returns a miss
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2
  } op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } ctrl_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // register request and per-cell match vector
    logic execute;  // apply update, load result register
  } dp_cmd_t;

endpackage

// ===== rtl/core/fkvc_ctrl.sv =====
// Controller FSM for the FIFO-replacement key/value cache core.
// Depends on fkvc_pkg; drives the datapath through dp_cmd_t.
module fkvc_ctrl
  import fkvc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_EXEC: begin
        cmd_o.execute = out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.execute) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/core/fkvc_dp.sv =====
// Datapath for the FIFO-replacement key/value cache core: row of key/value
// cells (slot 0 newest), parallel key compare, update and result register.
// Depends on fkvc_pkg.
module fkvc_dp
  import fkvc_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_cmd_t          cmd_i,
  input  logic [OP_W-1:0]  op_i,
  input  logic [KEY_W-1:0] key_i,
  input  logic [VAL_W-1:0] value_i,
  output logic             found_o,
  output logic [VAL_W-1:0] read_value_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [KEY_W-1:0]    key_q [CAPACITY];
  logic [VAL_W-1:0]    val_q [CAPACITY];
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CAPACITY-1:0] hit_q, hit_d;
  logic [OP_W-1:0]     op_q;
  logic [KEY_W-1:0]    req_key_q;
  logic [VAL_W-1:0]    req_val_q;
  logic                found_q, found_d;
  logic [VAL_W-1:0]    rdata_q, rdata_d;

  logic [CAPACITY-1:0] first_oh;
  logic [CAPACITY-1:0] at_or_above;
  logic                any_hit;
  logic [VAL_W-1:0]    hit_val;
  logic                do_insert, do_remove;

  // compare the incoming key against every valid cell
  always_comb begin
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      hit_d[i] = (CNT_W'(i) < cnt_q) && (key_q[i] == key_i);
    end
  end

  // newest match: lowest set bit; cells at or above it close the gap
  assign any_hit     = |hit_q;
  assign first_oh    = hit_q & (~hit_q + CAPACITY'(1));
  assign at_or_above = ~(first_oh - CAPACITY'(1));

  always_comb begin
    hit_val = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      if (first_oh[i]) hit_val = hit_val | val_q[i];
    end
  end

  assign do_insert = cmd_i.execute && (op_q == OP_INSERT);
  assign do_remove = cmd_i.execute && (op_q == OP_REMOVE) && any_hit;

  always_comb begin
    found_d = 1'b0;
    rdata_d = '0;
    cnt_d   = cnt_q;
    case (op_q)
      OP_INSERT: begin
        found_d = 1'b1;
        if (cnt_q != CNT_W'(CAPACITY)) cnt_d = cnt_q + CNT_W'(1);
      end
      OP_REMOVE: begin
        found_d = any_hit;
        if (any_hit) cnt_d = cnt_q - CNT_W'(1);
      end
      OP_LOOKUP: begin
        found_d = any_hit;
        rdata_d = hit_val;
      end
      default: begin
        found_d = 1'b0;
      end
    endcase
  end

  // cell row
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [KEY_W-1:0] older_key, newer_key;
    logic [VAL_W-1:0] older_val, newer_val;
    logic             pull;

    if (g == 0) begin : g_head
      assign newer_key = req_key_q;
      assign newer_val = req_val_q;
    end else begin : g_body
      assign newer_key = key_q[g-1];
      assign newer_val = val_q[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign older_key = key_q[g];
      assign older_val = val_q[g];
      assign pull      = 1'b0;
    end else begin : g_mid
      assign older_key = key_q[g+1];
      assign older_val = val_q[g+1];
      assign pull      = at_or_above[g];
    end

    always_ff @(posedge clk_i) begin
      if (do_insert) begin
        key_q[g] <= newer_key;
        val_q[g] <= newer_val;
      end else if (do_remove && pull) begin
        key_q[g] <= older_key;
        val_q[g] <= older_val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.execute) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      hit_q     <= hit_d;
      op_q      <= op_i;
      req_key_q <= key_i;
      req_val_q <= value_i;
    end
    if (cmd_i.execute) begin
      found_q <= found_d;
      rdata_q <= rdata_d;
    end
  end

  assign found_o      = found_q;
  assign read_value_o = rdata_q;

endmodule

// ===== rtl/core/fifo_replacement_key_value_cache_core.sv =====
// Top level of the FIFO-replacement key/value cache core.
// Instantiates fkvc_ctrl and fkvc_dp; depends on fkvc_pkg.
//
//  channel  | dir | tdata                       | tuser        | notes
//  ---------+-----+-----------------------------+--------------+----------------------
//  s_axis   | in  | item_key, item_value        | op (2 bits)  | one request per item
//  m_axis   | out | read_value                  | found        | one result per request
//
// Steps: when the result register is free, the accept cycle compares the key against
// all cells in parallel, and the next cycle finds the newest match, shifts the cell
// row and loads the result register.
// A result waiting on m_axis_tready holds the next item in its update step.
// Reset (rst_ni low, asynchronous) empties the store; the cells keep their
// data, only slots below the entry count are ever compared or read.
module fifo_replacement_key_value_cache_core
  import fkvc_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF  // 1 .. 256 entries
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [31:0] item_key, [63:32] item_value
  input  logic [OP_W-1:0]       s_axis_tuser,   // [1:0] op
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [31:0] read_value
  output logic                  m_axis_tuser    // [0] found
);

  dp_cmd_t cmd;

  fkvc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  fkvc_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .op_i         (s_axis_tuser),
    .key_i        (s_axis_tdata[KEY_W-1:0]),
    .value_i      (s_axis_tdata[KEY_W +: VAL_W]),
    .found_o      (m_axis_tuser),
    .read_value_o (m_axis_tdata)
  );

endmodule

// ===== rtl/core/fkvc_checker.sv =====
// Port-level checker for the FIFO-replacement key/value cache core,
// bound to the top level. Depends on fkvc_pkg.
module fkvc_checker
  import fkvc_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [IN_DATA_W-1:0]  s_axis_tdata,
  input logic [OP_W-1:0]       s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tuser
);

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // one transaction in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("back-to-back accept");

  // free output: result shows once the update step after the accept has loaded the result register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && !m_axis_tvalid |=> ##1 m_axis_tvalid)
    else $error("result late");

  // an insert always reports found, with zero read data
  a_insert_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (s_axis_tuser == OP_INSERT) && !m_axis_tvalid |=> ##1
      (m_axis_tuser && (m_axis_tdata == '0)))
    else $error("insert result wrong");

  // a miss returns zero data
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata == '0))
    else $error("miss with nonzero data");

endmodule

bind fifo_replacement_key_value_cache_core fkvc_checker u_fkvc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
